// ----- hdl/csort_pkg.sv -----
// csort_pkg: shared types, constants and the ordering test for the comb sorter
// used by comb_sorter, csort_shrink and tb; no dependencies

package csort_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 64;
    localparam int unsigned VALUE_W          = 32;

    // gap shrink factor of 1.3, as a ratio of two constants
    localparam int unsigned SHRINK_NUM = 10;
    localparam int unsigned SHRINK_DEN = 13;

    typedef struct packed {
        logic signed [VALUE_W-1:0] in_value;
        logic                      in_last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
    } t_out_item;

    // true when a must move behind b for the chosen order; equal values never swap
    function automatic logic out_of_order(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b,
        input logic                      desc
    );
        logic res;
        res = desc ? (a < b) : (a > b);
        return res;
    endfunction

endpackage

// ----- hdl/csort_ram.sv -----
// csort_ram: generic memory, one write port and two registered read ports
// no package dependency

module csort_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                         o_rdata_a,
    output logic [WIDTH-1:0]                         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- hdl/csort_shrink.sv -----
// csort_shrink: registered gap shrink unit, gap*10/13 clamped to at least one
// depends on csort_pkg for the shrink ratio

module csort_shrink
    import csort_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0] i_gap,
    output logic                              o_done,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0] o_gap
);

    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned XW = CW + 4;       // holds gap*10
    localparam int unsigned RS = XW + 4;       // reciprocal scale, error below 1/16
    localparam logic [RS-1:0] RM = RS'((64'd1 << RS) / SHRINK_DEN);

    logic [XW-1:0]    x;
    logic [XW+RS-1:0] prod;
    logic [XW-1:0]    r_x;
    logic [XW-1:0]    r_q0;
    logic             r_busy;
    logic [XW-1:0]    rem;
    logic [XW-1:0]    q;

    // gap*10 as shifts and one add
    assign x    = XW'({i_gap, 3'b000}) + XW'({i_gap, 1'b0});
    assign prod = (XW+RS)'(x) * (XW+RS)'(RM);

    // estimate is exact or one short
    assign rem = r_x - XW'(r_q0 * XW'(SHRINK_DEN));
    assign q   = (rem >= XW'(SHRINK_DEN)) ? r_q0 + 1'b1 : r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            o_done <= r_busy;
        end
        if (i_start) begin
            r_x  <= x;
            r_q0 <= prod[RS +: XW];
        end
        if (r_busy) begin
            o_gap <= (q == '0) ? CW'(1) : q[CW-1:0];
        end
    end

endmodule

// ----- hdl/comb_sorter.sv -----
// comb_sorter: top level, input store, comb sort sequencer and output register
// depends on csort_pkg, csort_ram and csort_shrink
//
// Collects signed 32-bit values, one per input transaction, into a store of
// MAX_ELEMENTS entries; values arriving once the store is full are dropped.
// The transaction marked last (stored or dropped) starts a comb sort of the
// stored set with shrink factor 1.3, in the order given by the descending
// register as it stands when that transaction arrives. The sorted set then
// leaves as one output transaction per element, the final one marked.
// Loading accepts an element whenever one is offered. The sort runs on one shared
// compare-and-swap path over a single-write memory: each pass takes a loop
// decision, the gap shrink and a closing bounds check, and each pair a read state
// and a compare state, plus a second write state when the pair is swapped. A set
// of 64 random values needs some 12 to 16 passes. Each output element is read and
// then handed to the output register, which waits while the sink stalls.
// Input is stalled from the last transaction until the final result has
// been handed to the output register.

module comb_sorter
    import csort_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    // output channel
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    // configuration write channel
    input  logic      i_cfg_valid,
    input  logic      i_cfg_data,
    output logic      o_cfg_ready
);

    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // loading elements
    localparam logic [2:0] ST_LOOP   = 3'd1;  // decide on another pass
    localparam logic [2:0] ST_SHRINK = 3'd2;  // wait for new gap
    localparam logic [2:0] ST_PAIR   = 3'd3;  // issue reads of a pair
    localparam logic [2:0] ST_CMP    = 3'd4;  // compare, write low side on swap
    localparam logic [2:0] ST_SWAP   = 3'd5;  // write high side
    localparam logic [2:0] ST_OUT_RD = 3'd6;  // read next sorted element
    localparam logic [2:0] ST_OUT_LD = 3'd7;  // hand it to the output register

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;    // elements held / set size
    logic [CW-1:0]      r_gap, n_gap;
    logic               r_swapped, n_swapped;
    logic [CW-1:0]      r_idx, n_idx;        // pair low index, then output index
    logic               r_desc;              // configuration register
    logic               r_sort_desc, n_sort_desc;
    logic [VALUE_W-1:0] r_hold, n_hold;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data, n_out_data;

    logic               in_accept;
    logic               store_en;
    logic [CW-1:0]      count_inc;
    logic [CW:0]        hi_idx;              // pair high index, one bit of headroom
    logic [CW:0]        idx_inc;
    logic               out_free;

    logic               shrink_start;
    logic               shrink_done;
    logic [CW-1:0]      shrink_gap;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [VALUE_W-1:0] rdata_a;
    logic [VALUE_W-1:0] rdata_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign store_en  = (r_count < CW'(MAX_ELEMENTS));
    assign count_inc = store_en ? r_count + 1'b1 : r_count;
    assign hi_idx    = (CW+1)'(r_idx) + (CW+1)'(r_gap);
    assign idx_inc   = (CW+1)'(r_idx) + 1'b1;
    // output register can take a new element this cycle
    assign out_free  = !r_out_valid || !i_out_stall;

    // element store
    csort_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (r_idx[AW-1:0]),
        .i_raddr_b (hi_idx[AW-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // gap shrink
    csort_shrink #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_shrink (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (shrink_start),
        .i_gap   (r_gap),
        .o_done  (shrink_done),
        .o_gap   (shrink_gap)
    );

    // single write port shared by loading and both halves of a swap
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = rdata_b;
        case (r_state)
            ST_IDLE: begin
                we    = in_accept && store_en;
                waddr = r_count[AW-1:0];
                wdata = i_in_data.in_value;
            end
            ST_CMP: begin
                we    = out_of_order(rdata_a, rdata_b, r_sort_desc);
                waddr = r_idx[AW-1:0];
                wdata = rdata_b;
            end
            ST_SWAP: begin
                we    = 1'b1;
                waddr = hi_idx[AW-1:0];
                wdata = r_hold;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_gap        = r_gap;
        n_swapped    = r_swapped;
        n_idx        = r_idx;
        n_sort_desc  = r_sort_desc;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        shrink_start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_count = count_inc;
                    if (i_in_data.in_last) begin
                        // latch order and start with gap equal to the set size
                        n_gap       = count_inc;
                        n_swapped   = 1'b1;
                        n_sort_desc = r_desc;
                        n_state     = ST_LOOP;
                    end
                end
            end
            ST_LOOP: begin
                if (!r_swapped && r_gap == CW'(1)) begin
                    n_idx   = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    shrink_start = 1'b1;
                    n_state      = ST_SHRINK;
                end
            end
            ST_SHRINK: begin
                if (shrink_done) begin
                    n_gap     = shrink_gap;
                    n_swapped = 1'b0;
                    n_idx     = '0;
                    n_state   = ST_PAIR;
                end
            end
            ST_PAIR: begin
                // reads of both ends are issued from the index registers
                if (hi_idx < (CW+1)'(r_count)) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_CMP: begin
                if (out_of_order(rdata_a, rdata_b, r_sort_desc)) begin
                    n_hold  = rdata_a;
                    n_state = ST_SWAP;
                end else begin
                    n_idx   = idx_inc[CW-1:0];
                    n_state = ST_PAIR;
                end
            end
            ST_SWAP: begin
                n_swapped = 1'b1;
                n_idx     = idx_inc[CW-1:0];
                n_state   = ST_PAIR;
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.out_value = rdata_a;
                    n_out_data.out_last  = (idx_inc == (CW+1)'(r_count));
                    if (idx_inc == (CW+1)'(r_count)) begin
                        // set delivered, store empty for the next one
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = idx_inc[CW-1:0];
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_gap       <= '0;
            r_swapped   <= 1'b0;
            r_idx       <= '0;
            r_desc      <= 1'b0;
            r_sort_desc <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_gap       <= n_gap;
            r_swapped   <= n_swapped;
            r_idx       <= n_idx;
            r_sort_desc <= n_sort_desc;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end
        end
        r_hold     <= n_hold;
        r_out_data <= n_out_data;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for comb_sorter, table-driven directed sets then random sets
// depends on csort_pkg and comb_sorter; carries its own sorting predictor

module tb
    import csort_pkg::*;
();

    localparam int unsigned STORE_DEPTH   = MAX_ELEMENTS_DEF;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 30;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned STALL_LIMIT   = 100000;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // one row of the directed table; want is only used where known is set
    typedef struct {
        logic                      desc;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        bit                        known;
        logic signed [VALUE_W-1:0] want;
    } t_dir_row;

    localparam int unsigned DIR_ROWS = 20;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // single-entry sets straight after reset: the value comes back unchanged
        '{1'b0, VAL_MIN,          1'b1, 1'b1, VAL_MIN},
        '{1'b0, VAL_MAX,          1'b1, 1'b1, VAL_MAX},
        '{1'b0, 32'sd0,           1'b1, 1'b1, 32'sd0},
        // equal values must never swap
        '{1'b0, 32'sd7,           1'b0, 1'b0, 32'sd0},
        '{1'b0, 32'sd7,           1'b0, 1'b0, 32'sd0},
        '{1'b0, 32'sd7,           1'b1, 1'b0, 32'sd0},
        // extremes and sign boundary, ascending
        '{1'b0, VAL_MAX,          1'b0, 1'b0, 32'sd0},
        '{1'b0, VAL_MIN,          1'b0, 1'b0, 32'sd0},
        '{1'b0, -32'sd1,          1'b0, 1'b0, 32'sd0},
        '{1'b0, 32'sd1,           1'b0, 1'b0, 32'sd0},
        '{1'b0, 32'sh5555_5555,   1'b0, 1'b0, 32'sd0},
        '{1'b0, 32'shaaaa_aaaa,   1'b1, 1'b0, 32'sd0},
        // descending order
        '{1'b1, -32'sd1,          1'b1, 1'b1, -32'sd1},
        '{1'b1, VAL_MIN,          1'b1, 1'b1, VAL_MIN},
        '{1'b1, VAL_MIN,          1'b0, 1'b0, 32'sd0},
        '{1'b1, 32'sd3,           1'b0, 1'b0, 32'sd0},
        '{1'b1, VAL_MAX,          1'b0, 1'b0, 32'sd0},
        '{1'b1, 32'sd3,           1'b0, 1'b0, 32'sd0},
        '{1'b1, -32'sd1,          1'b0, 1'b0, 32'sd0},
        '{1'b1, 32'sd0,           1'b1, 1'b0, 32'sd0}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data = 1'b0;
    logic      cfg_ready;

    // predictor state: the set being collected and the order register
    logic signed [VALUE_W-1:0] held_vals [STORE_DEPTH];
    int unsigned               held_count = 0;
    logic                      order_desc = 1'b0;

    t_out_item   sorted_q [$];
    int unsigned mismatches = 0;

    // idling controls shared between the source and the sink
    bit src_quiet  = 1'b0;
    bit sink_quiet = 1'b0;
    bit hold_req   = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    comb_sorter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    // cycles to idle before the next transaction; always zero when quiet, else zero in over a third of draws
    function automatic int unsigned draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // mix of extremes, a narrow band that yields many equal values, and full range
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                return VAL_MIN;
            end
            1: begin
                return VAL_MAX;
            end
            2, 3: begin
                return $signed($urandom_range(0, 8)) - 32'sd4;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // predictor: store the value while there is room; on the last mark run the
    // comb sort (shrink 10/13, floor 1) and queue the sorted set
    task automatic load_and_sort(input t_in_item it, input bit known,
                                 input logic signed [VALUE_W-1:0] want);
        int unsigned               gap;
        int unsigned               i;
        bit                        moved;
        logic signed [VALUE_W-1:0] tmp;
        t_out_item                 res;
        if (held_count < STORE_DEPTH) begin
            held_vals[held_count] = it.in_value;
            held_count++;
        end
        if (it.in_last) begin
            if (known) begin
                // table rows with a typed result are single-entry sets
                res.out_value = want;
                res.out_last  = 1'b1;
                sorted_q.push_back(res);
            end else begin
                gap   = held_count;
                moved = 1'b1;
                while (moved || gap != 1) begin
                    gap = (gap * SHRINK_NUM) / SHRINK_DEN;
                    if (gap < 1) begin
                        gap = 1;
                    end
                    moved = 1'b0;
                    for (i = 0; i + gap < held_count; i++) begin
                        if (order_desc ? (held_vals[i] < held_vals[i + gap])
                                       : (held_vals[i] > held_vals[i + gap])) begin
                            tmp                = held_vals[i];
                            held_vals[i]       = held_vals[i + gap];
                            held_vals[i + gap] = tmp;
                            moved              = 1'b1;
                        end
                    end
                end
                for (i = 0; i < held_count; i++) begin
                    res.out_value = held_vals[i];
                    res.out_last  = (i + 1 == held_count);
                    sorted_q.push_back(res);
                end
            end
            held_count = 0;
        end
    endtask

    // offer one transaction after a random gap; valid stays high for back-to-back items
    task automatic send_item(input t_in_item it, input bit known,
                             input logic signed [VALUE_W-1:0] want);
        int unsigned gap_cycles;
        gap_cycles = draw_wait(src_quiet);
        if (gap_cycles > 0) begin
            in_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        load_and_sort(it, known, want);
    endtask

    task automatic send_set(input int unsigned count);
        t_in_item    it;
        int unsigned k;
        for (k = 1; k <= count; k++) begin
            it.in_value = pick_value();
            it.in_last  = (k == count);
            send_item(it, 1'b0, '0);
        end
    endtask

    // sender pauses until every expected result has come, then lets the block go idle
    task automatic settle();
        in_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic desc);
        cfg_valid <= 1'b1;
        cfg_data  <= desc;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        order_desc = desc;
    endtask

    // sink: random stall before each result, one long hold on request
    initial begin : sink
        int unsigned pause;
        forever begin
            if (hold_req) begin
                pause    = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                pause = draw_wait(sink_quiet);
            end
            if (pause > 0) begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid && !hold_req);
        end
    end

    // compare every output transaction with the oldest expectation
    always @(posedge clk) begin : check_out
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual value %0d last %0b",
                         $time, out_data.out_value, out_data.out_last);
                mismatches++;
            end else begin
                want = sorted_q.pop_front();
                if (out_data.out_value !== want.out_value) begin
                    $display("%0t: out_value mismatch expected %0d actual %0d",
                             $time, want.out_value, out_data.out_value);
                    mismatches++;
                end
                if (out_data.out_last !== want.out_last) begin
                    $display("%0t: out_last mismatch expected %0b actual %0b",
                             $time, want.out_last, out_data.out_last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: ends the run once nothing has been accepted for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned r;
        int unsigned ph;
        int unsigned sent;
        int unsigned set_len;
        t_in_item    it;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_order(1'b0);

        // directed table; the order column changes only between sets
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].desc != order_desc) begin
                settle();
                write_order(dir_rows[r].desc);
            end
            it.in_value = dir_rows[r].value;
            it.in_last  = dir_rows[r].last;
            send_item(it, dir_rows[r].known, dir_rows[r].want);
        end

        // random phases, alternating the order register
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            write_order(ph[0]);
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            // one long sink hold while the source keeps offering, so the block backs up
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                set_len = $urandom_range(1, 12);
                // full store, exactly full, and the last transaction itself dropped
                if (sent == 0 && ph == 1) begin
                    set_len = STORE_DEPTH;
                end
                if (sent == 0 && ph == 4) begin
                    set_len = STORE_DEPTH + 2;
                end
                if (sent == 0 && ph == 6) begin
                    set_len = STORE_DEPTH + 1;
                end
                send_set(set_len);
                sent += set_len;
                if ($urandom_range(0, 5) == 0) begin
                    settle();
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
